@@ rtl/core/bhr_pkg.sv @@
package bhr_pkg;

    localparam int IMAGE_WIDTH  = 320;
    localparam int IMAGE_HEIGHT = 240;
    localparam int CORDIC_STEPS = 16;

    localparam int ANG_TABLE_LEN = 24;
    localparam int RUN_STEPS     = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS : ANG_TABLE_LEN;
    localparam int STEP_W        = 5;
    localparam int ANG_LIMIT     = 25736;

    // cordic datapath: scaled operands stay below 2^45 in magnitude
    localparam int DATA_W  = 48;
    localparam int SCALE_SH = 20;
    localparam int Z_W     = 32;

    localparam int COL_HALF_W = 10;
    localparam int ROW_HALF_W = 9;

    localparam int REG_EYE_MODE  = 0;
    localparam int REG_THRESHOLD = 1;
    localparam int REG_PERIOD    = 2;

    localparam logic [1:0] MODE_LEFT  = 2'd0;
    localparam logic [1:0] MODE_RIGHT = 2'd1;
    localparam logic [1:0] MODE_BOTH  = 2'd2;

    typedef struct packed {
        logic                          ok;
        logic signed [COL_HALF_W-1:0]  col_half;
        logic signed [ROW_HALF_W-1:0]  row_half;
    } front_t;

    typedef struct packed {
        logic                      start;
        logic signed [DATA_W-1:0]  y;
        logic signed [DATA_W-1:0]  x;
    } cordic_req_t;

    typedef struct packed {
        logic                done;
        logic signed [15:0]  angle;
    } cordic_rsp_t;

    // atan(2^-i) in Q2.30
    function automatic logic [30:0] ang_q30(input logic [STEP_W-1:0] idx);
        logic [30:0] a;
        case (idx)
            5'd0:    a = 31'd843314857;
            5'd1:    a = 31'd497837829;
            5'd2:    a = 31'd263043837;
            5'd3:    a = 31'd133525159;
            5'd4:    a = 31'd67021687;
            5'd5:    a = 31'd33543516;
            5'd6:    a = 31'd16775851;
            5'd7:    a = 31'd8388437;
            5'd8:    a = 31'd4194283;
            5'd9:    a = 31'd2097149;
            5'd10:   a = 31'd1048576;
            5'd11:   a = 31'd524288;
            5'd12:   a = 31'd262144;
            5'd13:   a = 31'd131072;
            5'd14:   a = 31'd65536;
            5'd15:   a = 31'd32768;
            5'd16:   a = 31'd16384;
            5'd17:   a = 31'd8192;
            5'd18:   a = 31'd4096;
            5'd19:   a = 31'd2048;
            5'd20:   a = 31'd1024;
            5'd21:   a = 31'd512;
            5'd22:   a = 31'd256;
            5'd23:   a = 31'd128;
            default: a = 31'd0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/core/bhr_if.sv @@
interface bhr_in_if;
    logic        valid;
    logic        ready;
    logic [8:0]  left_col;
    logic [7:0]  left_row;
    logic [15:0] left_conf;
    logic [8:0]  right_col;
    logic [7:0]  right_row;
    logic [15:0] right_conf;

    modport source (
        output valid, left_col, left_row, left_conf, right_col, right_row, right_conf,
        input  ready
    );
    modport sink (
        input  valid, left_col, left_row, left_conf, right_col, right_row, right_conf,
        output ready
    );
endinterface

interface bhr_out_if;
    logic               valid;
    logic               ready;
    logic               found;
    logic signed [15:0] pan_angle;
    logic signed [15:0] tilt_angle;
    logic signed [15:0] pan_rate_angle;
    logic signed [15:0] tilt_rate_angle;

    modport source (
        output valid, found, pan_angle, tilt_angle, pan_rate_angle, tilt_rate_angle,
        input  ready
    );
    modport sink (
        input  valid, found, pan_angle, tilt_angle, pan_rate_angle, tilt_rate_angle,
        output ready
    );
endinterface

@@ rtl/core/blob_heading_and_rate.sv @@
// an item that fails the gate goes to the output register with no cordic job; one that
// passes first runs four cordic atan2 jobs in turn (pan, tilt, pan rate, tilt rate),
// each a load, 16 steps and done; the result enters the output register once it is free
// (empty, or its result taken); a new item is taken only after the last one is there
// the single shared cordic unit runs the four jobs one after another
// the next item is taken while a finished result still waits at the output register
// reset: asynchronous active low; eye_mode 2, conf_threshold 32768, period_us 33333,
// stored positions and held angles zero
module blob_heading_and_rate (
    input  logic        clk,
    input  logic        rst_n,
    bhr_in_if.sink      item,
    bhr_out_if.source   result,
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import bhr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_START   = 4'b0010,
        S_WAIT    = 4'b0100,
        S_DELIVER = 4'b1000
    } state_t;

    state_t state_reg;

    logic [1:0]  eye_mode_reg;
    logic [15:0] threshold_reg;
    logic [19:0] period_reg;

    logic                         ok_reg;
    logic signed [COL_HALF_W-1:0] col_reg;
    logic signed [ROW_HALF_W-1:0] row_reg;
    logic signed [COL_HALF_W-1:0] prev_col_reg;
    logic signed [ROW_HALF_W-1:0] prev_row_reg;
    logic [1:0]                   job_reg;
    logic signed [15:0]           ang_reg [4];
    logic signed [15:0]           held_reg [4];

    logic               out_valid_reg;
    logic               out_found_reg;
    logic signed [15:0] out_ang_reg [4];

    front_t      front;
    cordic_req_t req;
    cordic_rsp_t rsp;

    logic signed [COL_HALF_W:0] dcol;
    logic signed [COL_HALF_W:0] drow;
    logic signed [COL_HALF_W:0] dsel;
    logic signed [26:0]         rate_y;
    logic [19:0]                per_eff;
    logic [23:0]                rate_x;
    logic signed [26:0]         y_small;
    logic [23:0]                x_small;
    logic                       out_free;

    bhr_front u_front (
        .left_col       (item.left_col),
        .left_row       (item.left_row),
        .left_conf      (item.left_conf),
        .right_col      (item.right_col),
        .right_row      (item.right_row),
        .right_conf     (item.right_conf),
        .eye_mode       (eye_mode_reg),
        .conf_threshold (threshold_reg),
        .front          (front)
    );

    bhr_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // operands of the current job: pan, tilt, pan rate, tilt rate
    always_comb
    begin
        dcol    = (COL_HALF_W+1)'(col_reg) - (COL_HALF_W+1)'(prev_col_reg);
        drow    = (COL_HALF_W+1)'(row_reg) - (COL_HALF_W+1)'(prev_row_reg);
        dsel    = job_reg[0] ? drow : dcol;
        rate_y  = 27'(dsel) * 27'sd20000;
        per_eff = (period_reg == 20'd0) ? 20'd1 : period_reg;
        rate_x  = {4'b0000, per_eff} * 24'd9;

        case (job_reg)
            2'd0:
            begin
                y_small = 27'(col_reg);
                x_small = 24'd450;
            end
            2'd1:
            begin
                y_small = 27'(row_reg);
                x_small = 24'd450;
            end
            default:
            begin
                y_small = rate_y;
                x_small = rate_x;
            end
        endcase

        req.start = (state_reg == S_START);
        req.y     = DATA_W'(y_small) <<< SCALE_SH;
        req.x     = $signed({4'b0000, x_small, 20'b0});
    end

    assign out_free   = !out_valid_reg || result.ready;
    assign item.ready = (state_reg == S_IDLE);

    assign result.valid           = out_valid_reg;
    assign result.found           = out_found_reg;
    assign result.pan_angle       = out_ang_reg[0];
    assign result.tilt_angle      = out_ang_reg[1];
    assign result.pan_rate_angle  = out_ang_reg[2];
    assign result.tilt_rate_angle = out_ang_reg[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_mode_reg  <= MODE_BOTH;
            threshold_reg <= 16'd32768;
            period_reg    <= 20'd33333;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                2'(REG_EYE_MODE):  eye_mode_reg  <= cfg_data[1:0];
                2'(REG_THRESHOLD): threshold_reg <= cfg_data[15:0];
                2'(REG_PERIOD):    period_reg    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            job_reg       <= 2'd0;
            prev_col_reg  <= '0;
            prev_row_reg  <= '0;
            for (int k = 0; k < 4; k++)
                held_reg[k] <= '0;
        end
        else
        begin
            if (state_reg == S_DELIVER && out_free)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (item.valid)
                    begin
                        job_reg   <= 2'd0;
                        state_reg <= front.ok ? S_START : S_DELIVER;
                    end
                end
                S_START:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (rsp.done)
                    begin
                        job_reg   <= job_reg + 2'd1;
                        state_reg <= (job_reg == 2'd3) ? S_DELIVER : S_START;
                    end
                end
                S_DELIVER:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                        if (ok_reg)
                        begin
                            prev_col_reg <= col_reg;
                            prev_row_reg <= row_reg;
                            for (int k = 0; k < 4; k++)
                                held_reg[k] <= ang_reg[k];
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && item.valid)
        begin
            ok_reg  <= front.ok;
            col_reg <= front.col_half;
            row_reg <= front.row_half;
        end
        if (state_reg == S_WAIT && rsp.done)
            ang_reg[job_reg] <= rsp.angle;
        if (state_reg == S_DELIVER && out_free)
        begin
            out_found_reg <= ok_reg;
            for (int k = 0; k < 4; k++)
                out_ang_reg[k] <= ok_reg ? ang_reg[k] : held_reg[k];
        end
    end

endmodule

@@ rtl/core/bhr_front.sv @@
module bhr_front (
    input  logic [8:0]       left_col,
    input  logic [7:0]       left_row,
    input  logic [15:0]      left_conf,
    input  logic [8:0]       right_col,
    input  logic [7:0]       right_row,
    input  logic [15:0]      right_conf,
    input  logic [1:0]       eye_mode,
    input  logic [15:0]      conf_threshold,
    output bhr_pkg::front_t  front
);
    import bhr_pkg::*;

    localparam logic [8:0] COL_MAX = 9'(IMAGE_WIDTH - 1);
    localparam logic [7:0] ROW_MAX = 8'(IMAGE_HEIGHT - 1);

    logic [8:0]         lc;
    logic [8:0]         rc;
    logic [7:0]         lr;
    logic [7:0]         rr;
    logic               lok;
    logic               rok;
    logic signed [11:0] col_sum;
    logic signed [10:0] row_sum;

    always_comb
    begin
        lc  = (left_col > COL_MAX) ? COL_MAX : left_col;
        rc  = (right_col > COL_MAX) ? COL_MAX : right_col;
        lr  = (left_row > ROW_MAX) ? ROW_MAX : left_row;
        rr  = (right_row > ROW_MAX) ? ROW_MAX : right_row;
        lok = left_conf > conf_threshold;
        rok = right_conf > conf_threshold;

        case (eye_mode)
            MODE_LEFT:
            begin
                front.ok = lok;
                col_sum  = $signed({2'b00, lc, 1'b0});
                row_sum  = $signed({2'b00, lr, 1'b0});
            end
            MODE_RIGHT:
            begin
                front.ok = rok;
                col_sum  = $signed({2'b00, rc, 1'b0});
                row_sum  = $signed({2'b00, rr, 1'b0});
            end
            default:
            begin
                // unused mode code behaves as both
                front.ok = lok && rok;
                col_sum  = $signed({3'b000, lc}) + $signed({3'b000, rc});
                row_sum  = $signed({3'b000, lr}) + $signed({3'b000, rr});
            end
        endcase

        col_sum = col_sum - 12'(IMAGE_WIDTH);
        row_sum = row_sum - 11'(IMAGE_HEIGHT);
        front.col_half = col_sum[COL_HALF_W-1:0];
        front.row_half = row_sum[ROW_HALF_W-1:0];
    end

endmodule

@@ rtl/core/bhr_cordic.sv @@
module bhr_cordic (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bhr_pkg::cordic_req_t  req,
    output bhr_pkg::cordic_rsp_t  rsp
);
    import bhr_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(RUN_STEPS - 1);

    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] y_reg;
    logic signed [Z_W-1:0]    z_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic signed [DATA_W-1:0] dx;
    logic signed [DATA_W-1:0] dy;
    logic signed [Z_W-1:0]    ang;
    logic signed [Z_W:0]      z_round;
    logic signed [Z_W:0]      z_q14;

    assign dx  = y_reg >>> step_reg;
    assign dy  = x_reg >>> step_reg;
    assign ang = $signed({1'b0, ang_q30(step_reg)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == LAST_STEP)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // micro-rotation, direction from the sign of y before the step
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg    <= req.x;
            y_reg    <= req.y;
            z_reg    <= '0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!y_reg[DATA_W-1])
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + ang;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - ang;
            end
            step_reg <= step_reg + 1'b1;
        end
    end

    // round Q2.30 to Q2.14 and clamp
    always_comb
    begin
        z_round = (Z_W+1)'(z_reg) + 33'sd32768;
        z_q14   = z_round >>> 16;
        if (z_q14 > 33'sd25736)
            rsp.angle = 16'sd25736;
        else if (z_q14 < -33'sd25736)
            rsp.angle = -16'sd25736;
        else
            rsp.angle = z_q14[15:0];
        rsp.done = done_reg;
    end

endmodule

@@ dv/tb_blob_heading_and_rate.sv @@
module tb_blob_heading_and_rate;
    timeunit 1ns;
    timeprecision 1ps;

    import bhr_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ATAN_STEPS  = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
    localparam int FOCAL_HALF  = 450;
    localparam int RATE_GAIN   = 20000;
    localparam int PERIOD_GAIN = 9;

    // eye_mode code with no defined meaning, handled like both
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // receiver stall styles
    localparam int RCV_ALWAYS  = 0;
    localparam int RCV_RANDOM  = 1;
    localparam int RCV_PATTERN = 2;
    localparam int RCV_SPARSE  = 3;

    // atan(2^-i) in Q2.30
    localparam longint ATAN_Q30 [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128
    };

    typedef struct packed {
        logic [8:0]  lcol;
        logic [7:0]  lrow;
        logic [15:0] lconf;
        logic [8:0]  rcol;
        logic [7:0]  rrow;
        logic [15:0] rconf;
    } blob_pair_t;

    typedef struct packed {
        logic               found;
        logic signed [15:0] pan;
        logic signed [15:0] tilt;
        logic signed [15:0] pan_rate;
        logic signed [15:0] tilt_rate;
    } heading_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_wen;
    logic [1:0]  cfg_index;
    logic [19:0] cfg_data;

    bhr_in_if  item_if ();
    bhr_out_if result_if ();

    blob_heading_and_rate dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_if),
        .result    (result_if),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of registers and tracking state
    logic [1:0]         mdl_mode   = MODE_BOTH;
    logic [15:0]        mdl_thresh = 16'd32768;
    logic [19:0]        mdl_period = 20'd33333;
    int                 last_col   = 0;
    int                 last_row   = 0;
    logic signed [15:0] held_pan       = '0;
    logic signed [15:0] held_tilt      = '0;
    logic signed [15:0] held_pan_rate  = '0;
    logic signed [15:0] held_tilt_rate = '0;

    heading_t   pending_headings [$];
    int         heading_errors = 0;
    int         cycle_count    = 0;

    int         rcv_mode    = RCV_ALWAYS;
    logic [15:0] rcv_pattern = 16'hFFFF;
    int         holdoff_len = 0;
    int         holdoff_seq = 0;
    bit         pacing      = 1'b0;
    int         burst_left  = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver ready: stall style per phase, plus long hold-offs on request
    initial
    begin : ready_driver
        int seen_seq;
        int holdoff_left;
        logic [3:0] pat_pos;
        seen_seq = 0;
        holdoff_left = 0;
        pat_pos = '0;
        result_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_seq != seen_seq)
            begin
                seen_seq = holdoff_seq;
                holdoff_left = holdoff_len;
            end
            pat_pos = pat_pos + 1'b1;
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_if.ready <= 1'b0;
            end
            else
            begin
                case (rcv_mode)
                    RCV_RANDOM:  result_if.ready <= 1'($urandom_range(0, 1));
                    RCV_PATTERN: result_if.ready <= rcv_pattern[pat_pos];
                    RCV_SPARSE:  result_if.ready <= ($urandom_range(0, 7) != 0);
                    default:     result_if.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        heading_t got;
        heading_t want;
        if (rst_n === 1'b1 && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            got.found     = result_if.found;
            got.pan       = result_if.pan_angle;
            got.tilt      = result_if.tilt_angle;
            got.pan_rate  = result_if.pan_rate_angle;
            got.tilt_rate = result_if.tilt_rate_angle;
            if (pending_headings.size() == 0)
            begin
                heading_errors++;
                if (heading_errors <= 10)
                    $display("%0t: result transfer with nothing expected: found=%0d pan=%0d",
                             $realtime, got.found, got.pan);
            end
            else
            begin
                want = pending_headings.pop_front();
                if (got !== want)
                begin
                    heading_errors++;
                    if (heading_errors <= 10)
                    begin
                        $display("%0t: mismatch exp found=%0d pan=%0d tilt=%0d prate=%0d trate=%0d",
                                 $realtime, want.found, want.pan, want.tilt,
                                 want.pan_rate, want.tilt_rate);
                        $display("%0t:          got found=%0d pan=%0d tilt=%0d prate=%0d trate=%0d",
                                 $realtime, got.found, got.pan, got.tilt,
                                 got.pan_rate, got.tilt_rate);
                    end
                end
            end
        end
    end

    function automatic logic signed [15:0] cordic_atan2(longint y, longint x);
        longint xs;
        longint ys;
        longint z;
        longint dx;
        longint dy;
        longint r;
        xs = x <<< SCALE_SH;
        ys = y <<< SCALE_SH;
        z = 0;
        for (int i = 0; i < ATAN_STEPS; i++)
        begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys >= 0)
            begin
                xs = xs + dx;
                ys = ys - dy;
                z = z + ATAN_Q30[i];
            end
            else
            begin
                xs = xs - dx;
                ys = ys + dy;
                z = z - ATAN_Q30[i];
            end
        end
        r = (z + 32768) >>> 16;
        if (r > ANG_LIMIT)
            r = ANG_LIMIT;
        if (r < -ANG_LIMIT)
            r = -ANG_LIMIT;
        return r[15:0];
    endfunction

    function automatic int clip_pos(int v, int size);
        return (v > size - 1) ? size - 1 : v;
    endfunction

    function automatic heading_t predict_heading(blob_pair_t b);
        int       lc;
        int       lr;
        int       rc;
        int       rr;
        int       ccol;
        int       crow;
        bit       lok;
        bit       rok;
        bit       ok;
        longint   per;
        heading_t res;
        lc = clip_pos(int'(b.lcol), IMAGE_WIDTH);
        lr = clip_pos(int'(b.lrow), IMAGE_HEIGHT);
        rc = clip_pos(int'(b.rcol), IMAGE_WIDTH);
        rr = clip_pos(int'(b.rrow), IMAGE_HEIGHT);
        lok = b.lconf > mdl_thresh;
        rok = b.rconf > mdl_thresh;
        case (mdl_mode)
            MODE_LEFT:
            begin
                ok = lok;
                ccol = 2 * lc - IMAGE_WIDTH;
                crow = 2 * lr - IMAGE_HEIGHT;
            end
            MODE_RIGHT:
            begin
                ok = rok;
                ccol = 2 * rc - IMAGE_WIDTH;
                crow = 2 * rr - IMAGE_HEIGHT;
            end
            default:
            begin
                ok = lok && rok;
                ccol = lc + rc - IMAGE_WIDTH;
                crow = lr + rr - IMAGE_HEIGHT;
            end
        endcase
        if (ok)
        begin
            per = (mdl_period == 0) ? 1 : longint'(mdl_period);
            held_pan       = cordic_atan2(ccol, FOCAL_HALF);
            held_tilt      = cordic_atan2(crow, FOCAL_HALF);
            held_pan_rate  = cordic_atan2(longint'(ccol - last_col) * RATE_GAIN,
                                          PERIOD_GAIN * per);
            held_tilt_rate = cordic_atan2(longint'(crow - last_row) * RATE_GAIN,
                                          PERIOD_GAIN * per);
            last_col = ccol;
            last_row = crow;
        end
        res.found     = ok;
        res.pan       = held_pan;
        res.tilt      = held_tilt;
        res.pan_rate  = held_pan_rate;
        res.tilt_rate = held_tilt_rate;
        return res;
    endfunction

    function automatic blob_pair_t make_blob(int lc, int lr, int lconf, int rc, int rr,
                                             int rconf);
        blob_pair_t b;
        b.lcol  = lc[8:0];
        b.lrow  = lr[7:0];
        b.lconf = lconf[15:0];
        b.rcol  = rc[8:0];
        b.rrow  = rr[7:0];
        b.rconf = rconf[15:0];
        return b;
    endfunction

    function automatic logic [15:0] rand_conf(bit pass);
        if (pass)
            return (mdl_thresh == 16'hFFFF) ? 16'hFFFF
                                            : 16'($urandom_range(mdl_thresh + 1, 65535));
        case ($urandom_range(0, 2))
            0:       return mdl_thresh;
            1:       return 16'($urandom_range(0, mdl_thresh));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic blob_pair_t rand_blob(blob_pair_t prev);
        blob_pair_t b;
        bit         well;
        well = ($urandom_range(0, 9) < 8);
        b = prev;
        // a repeated position gives a zero rate
        if ($urandom_range(0, 9) != 0)
        begin
            b.lcol = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                 : 9'($urandom_range(0, IMAGE_WIDTH - 1));
            b.rcol = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                 : 9'($urandom_range(0, IMAGE_WIDTH - 1));
            b.lrow = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, IMAGE_HEIGHT - 1));
            b.rrow = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, IMAGE_HEIGHT - 1));
        end
        b.lconf = rand_conf(well || $urandom_range(0, 1));
        b.rconf = rand_conf(well || $urandom_range(0, 1));
        return b;
    endfunction

    task automatic offer_blob(blob_pair_t b);
        item_if.valid      <= 1'b1;
        item_if.left_col   <= b.lcol;
        item_if.left_row   <= b.lrow;
        item_if.left_conf  <= b.lconf;
        item_if.right_col  <= b.rcol;
        item_if.right_row  <= b.rrow;
        item_if.right_conf <= b.rconf;
        @(posedge clk);
        while (item_if.ready !== 1'b1)
            @(posedge clk);
        pending_headings.push_back(predict_heading(b));
    endtask

    // sender bursts with random gaps, short or long
    task automatic pace_sender();
        int gap;
        if (!pacing)
            return;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 120)
                                              : $urandom_range(1, 12);
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        while (pending_headings.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_register(int idx, logic [19:0] value);
        wait_drained();
        @(posedge clk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx[1:0];
        cfg_data  <= value;
        @(posedge clk);
        cfg_wen <= 1'b0;
        case (idx)
            REG_EYE_MODE:  mdl_mode   = value[1:0];
            REG_THRESHOLD: mdl_thresh = value[15:0];
            REG_PERIOD:    mdl_period = value;
            default:       ;
        endcase
    endtask

    task automatic test_reset_config();
        // confidence equal to the threshold fails, so held angles stay zero
        offer_blob(make_blob(100, 50, 32768, 200, 60, 32768));
        offer_blob(make_blob(0, 0, 32769, 0, 0, 32769));
        offer_blob(make_blob(319, 239, 65535, 319, 239, 65535));
        // beyond the image: saturates to the last column and row
        offer_blob(make_blob(511, 255, 65535, 511, 255, 65535));
        offer_blob(make_blob(160, 120, 65535, 10, 20, 1000));
        offer_blob(make_blob(160, 120, 65535, 160, 120, 65535));
    endtask

    task automatic test_eye_modes();
        set_register(REG_EYE_MODE, 20'(MODE_LEFT));
        offer_blob(make_blob(300, 10, 40000, 5, 200, 100));
        offer_blob(make_blob(20, 230, 100, 5, 200, 40000));
        set_register(REG_EYE_MODE, 20'(MODE_RIGHT));
        offer_blob(make_blob(300, 10, 40000, 5, 200, 100));
        offer_blob(make_blob(20, 230, 100, 310, 5, 40000));
        set_register(REG_EYE_MODE, 20'(MODE_SPARE));
        offer_blob(make_blob(10, 200, 50000, 300, 30, 50000));
        offer_blob(make_blob(10, 200, 50000, 300, 30, 0));
        set_register(REG_EYE_MODE, 20'(MODE_BOTH));
    endtask

    task automatic test_threshold_extremes();
        set_register(REG_THRESHOLD, 20'd0);
        offer_blob(make_blob(50, 50, 0, 60, 60, 0));
        offer_blob(make_blob(50, 50, 1, 60, 60, 1));
        set_register(REG_THRESHOLD, 20'd65535);
        offer_blob(make_blob(250, 150, 65535, 250, 150, 65535));
        set_register(REG_THRESHOLD, 20'd32768);
    endtask

    task automatic test_period_extremes();
        // zero period counts as one microsecond
        set_register(REG_PERIOD, 20'd0);
        offer_blob(make_blob(0, 0, 65535, 0, 0, 65535));
        set_register(REG_PERIOD, 20'd1);
        offer_blob(make_blob(319, 239, 65535, 319, 239, 65535));
        set_register(REG_PERIOD, 20'd1000000);
        offer_blob(make_blob(318, 238, 65535, 319, 239, 65535));
        set_register(REG_PERIOD, 20'hFFFFF);
        offer_blob(make_blob(0, 239, 65535, 0, 239, 65535));
        set_register(REG_PERIOD, 20'd33333);
    endtask

    task automatic test_backpressure();
        blob_pair_t b;
        b = make_blob(160, 120, 65535, 160, 120, 65535);
        rcv_mode = RCV_ALWAYS;
        pacing = 1'b0;
        holdoff_len = 1000;
        holdoff_seq++;
        // offered back to back while results are held off, so the block stalls its input
        repeat (8)
        begin
            b = rand_blob(b);
            b.lconf = 16'hFFFF;
            b.rconf = 16'hFFFF;
            offer_blob(b);
        end
        wait_drained();
    endtask

    task automatic test_random();
        blob_pair_t b;
        logic [19:0] per;
        logic [15:0] thr;
        b = make_blob(160, 120, 65535, 160, 120, 65535);
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 5)
                0:       thr = 16'd0;
                1:       thr = 16'd32768;
                2:       thr = 16'd60000;
                3:       thr = 16'd1000;
                default: thr = 16'($urandom_range(0, 65534));
            endcase
            case ($urandom_range(0, 5))
                0:       per = 20'd0;
                1:       per = 20'd1;
                2:       per = 20'd1000000;
                3:       per = 20'hFFFFF;
                4:       per = 20'd33333;
                default: per = 20'($urandom_range(1, 1000000));
            endcase
            set_register(REG_EYE_MODE,
                         (phase < 4) ? 20'(phase) : 20'($urandom_range(0, 3)));
            set_register(REG_THRESHOLD, 20'(thr));
            set_register(REG_PERIOD, per);
            rcv_mode = phase % 4;
            rcv_pattern = 16'($urandom) | 16'h0001;
            pacing = (phase != 0) && (phase != 5);
            burst_left = 0;
            repeat (140)
            begin
                pace_sender();
                b = rand_blob(b);
                offer_blob(b);
                if ($urandom_range(0, 49) == 0)
                    wait_drained();
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wen   <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        item_if.valid      <= 1'b0;
        item_if.left_col   <= '0;
        item_if.left_row   <= '0;
        item_if.left_conf  <= '0;
        item_if.right_col  <= '0;
        item_if.right_row  <= '0;
        item_if.right_conf <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_eye_modes();
        test_threshold_extremes();
        test_period_extremes();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (100) @(posedge clk);
        if (heading_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/bhr_pkg.sv
rtl/core/bhr_if.sv
rtl/core/bhr_front.sv
rtl/core/bhr_cordic.sv
rtl/core/blob_heading_and_rate.sv
dv/tb_blob_heading_and_rate.sv
